### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define GNC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define GNC_ASSERT(lbl, prop, msg) \
  `GNC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/gnc_pkg.sv
`timescale 1ns / 1ps
package gnc_pkg;

  localparam int unsigned RowW  = 8;
  localparam int unsigned ColW  = 8;
  localparam int unsigned AddrW = RowW + ColW;
  localparam int unsigned MaxCols = 1 << ColW;
  localparam int unsigned MaxRows = 1 << RowW;
  localparam int unsigned DimW  = 9;   // grid_width / grid_height registers
  localparam int unsigned WordW = 16;
  localparam int unsigned CntW  = 4;
  localparam int unsigned PcW   = 5;

  localparam logic [DimW-1:0] MaxColsDim = DimW'(MaxCols);
  localparam logic [DimW-1:0] MaxRowsDim = DimW'(MaxRows);

  typedef enum logic [1:0] {
    RegGridWidth  = 2'd0,
    RegGridHeight = 2'd1,
    RegHexPack    = 2'd2,
    RegLiveBits   = 2'd3
  } reg_idx_e;

  typedef enum logic [0:0] {
    CmdWrite = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OpCtr  = 2'd0,  // read the addressed word
    OpNbr  = 2'd1,  // read one neighbor and count it
    OpWr   = 2'd2,  // store the flag word
    OpEmit = 2'd3   // hand the result to the output register
  } op_e;

  typedef enum logic [1:0] {
    JmpNext = 2'd0,
    JmpGoto = 2'd1,
    JmpDisp = 2'd2
  } jmp_e;

  typedef struct packed {
    op_e            op;
    logic [1:0]     dr;      // two's complement row offset
    logic [1:0]     dc;      // two's complement column offset
    logic           hex_adj; // shift column by -1 on even rows
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic pos_valid;
    logic is_write;
    logic hex;
  } seq_status_t;

  localparam logic [PcW-1:0] StepCtr  = PcW'(0);
  localparam logic [PcW-1:0] StepSq   = PcW'(1);
  localparam logic [PcW-1:0] StepHex  = PcW'(9);
  localparam logic [PcW-1:0] StepEmit = PcW'(15);
  localparam logic [PcW-1:0] StepWr   = PcW'(16);

  localparam logic [1:0] OffM1 = 2'b11;
  localparam logic [1:0] Off0  = 2'b00;
  localparam logic [1:0] OffP1 = 2'b01;

  function automatic ctrl_t mk(op_e op, logic [1:0] dr, logic [1:0] dc, logic adj,
                               jmp_e jmp, logic [PcW-1:0] tgt);
    ctrl_t c;
    c.op      = op;
    c.dr      = dr;
    c.dc      = dc;
    c.hex_adj = adj;
    c.jmp     = jmp;
    c.target  = tgt;
    return c;
  endfunction

  // Microprogram: centre read and dispatch, square walk, hex walk, emit, write.
  function automatic ctrl_t prog_rom(logic [PcW-1:0] pc);
    ctrl_t c;
    case (pc)
      StepCtr:          c = mk(OpCtr, Off0, Off0, 1'b0, JmpDisp, StepSq);
      StepSq + 5'd0:    c = mk(OpNbr, OffM1, OffM1, 1'b0, JmpNext, StepCtr);
      StepSq + 5'd1:    c = mk(OpNbr, OffM1, Off0,  1'b0, JmpNext, StepCtr);
      StepSq + 5'd2:    c = mk(OpNbr, OffM1, OffP1, 1'b0, JmpNext, StepCtr);
      StepSq + 5'd3:    c = mk(OpNbr, Off0,  OffM1, 1'b0, JmpNext, StepCtr);
      StepSq + 5'd4:    c = mk(OpNbr, Off0,  OffP1, 1'b0, JmpNext, StepCtr);
      StepSq + 5'd5:    c = mk(OpNbr, OffP1, OffM1, 1'b0, JmpNext, StepCtr);
      StepSq + 5'd6:    c = mk(OpNbr, OffP1, Off0,  1'b0, JmpNext, StepCtr);
      StepSq + 5'd7:    c = mk(OpNbr, OffP1, OffP1, 1'b0, JmpGoto, StepEmit);
      StepHex + 5'd0:   c = mk(OpNbr, OffM1, OffP1, 1'b1, JmpNext, StepCtr);
      StepHex + 5'd1:   c = mk(OpNbr, OffM1, Off0,  1'b1, JmpNext, StepCtr);
      StepHex + 5'd2:   c = mk(OpNbr, OffP1, OffP1, 1'b1, JmpNext, StepCtr);
      StepHex + 5'd3:   c = mk(OpNbr, OffP1, Off0,  1'b1, JmpNext, StepCtr);
      StepHex + 5'd4:   c = mk(OpNbr, Off0,  OffM1, 1'b0, JmpNext, StepCtr);
      StepHex + 5'd5:   c = mk(OpNbr, Off0,  OffP1, 1'b0, JmpNext, StepCtr);
      StepWr:           c = mk(OpWr,  Off0,  Off0,  1'b0, JmpGoto, StepEmit);
      default:          c = mk(OpEmit, Off0, Off0,  1'b0, JmpNext, StepCtr);
    endcase
    return c;
  endfunction

endpackage

### rtl/gnc_seq.sv
`timescale 1ns / 1ps
module gnc_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gnc_pkg::seq_status_t status_i,
  input  logic                emit_go_i,
  output logic                busy_o,
  output gnc_pkg::ctrl_t      ctrl_o
);

  logic                     busy_q, busy_d;
  logic [gnc_pkg::PcW-1:0]  pc_q, pc_d;

  assign ctrl_o = gnc_pkg::prog_rom(pc_q);
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = gnc_pkg::StepCtr;
      end
    end else if (ctrl_o.op == gnc_pkg::OpEmit) begin
      // hold here until the output register frees up
      if (emit_go_i) begin
        busy_d = 1'b0;
      end
    end else begin
      unique case (ctrl_o.jmp)
        gnc_pkg::JmpGoto: pc_d = ctrl_o.target;
        gnc_pkg::JmpDisp: begin
          if (!status_i.pos_valid) begin
            pc_d = gnc_pkg::StepEmit;
          end else if (status_i.is_write) begin
            pc_d = gnc_pkg::StepWr;
          end else if (status_i.hex) begin
            pc_d = gnc_pkg::StepHex;
          end else begin
            pc_d = gnc_pkg::StepSq;
          end
        end
        default: pc_d = pc_q + gnc_pkg::PcW'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= gnc_pkg::StepCtr;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

### rtl/grid_live_neighbor_count_core.sv
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid_i/in_stall_o cmd_i, row_index_i, col_index_i, flag_word_i
// out      out_valid_o/out_stall_i live_count_o, stored_word_o, position_valid_o
// config   APB psel/penable      paddr[3:0], pwdata, prdata (32 bit)
//
// From accept to result register load, a query reads the centre word and then each
// neighbor, a write stores the word, and a position outside the grid goes straight
// to the load; the single-port flag memory serves one neighbor read per step.
// Reset gives width and height 256, square packing, live_bits 0; memory contents
// are undefined until written. A new item is taken once the previous one reached
// the output register, even while that result is still stalled.
module grid_live_neighbor_count_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  cmd_i,
  input  logic [7:0]  row_index_i,
  input  logic [7:0]  col_index_i,
  input  logic [15:0] flag_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  live_count_o,
  output logic [15:0] stored_word_o,
  output logic        position_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = gnc_pkg::DimW + 1;  // signed neighbor coordinate

  // configuration
  logic [gnc_pkg::DimW-1:0]  grid_width_q, grid_height_q;
  logic                      hex_pack_q;
  logic [gnc_pkg::WordW-1:0] live_bits_q;
  logic [gnc_pkg::DimW-1:0]  eff_w, eff_h;
  gnc_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = gnc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= gnc_pkg::MaxColsDim;
      grid_height_q <= gnc_pkg::MaxRowsDim;
      hex_pack_q    <= 1'b0;
      live_bits_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        gnc_pkg::RegGridWidth:  grid_width_q  <= pwdata[gnc_pkg::DimW-1:0];
        gnc_pkg::RegGridHeight: grid_height_q <= pwdata[gnc_pkg::DimW-1:0];
        gnc_pkg::RegHexPack:    hex_pack_q    <= pwdata[0];
        default:                live_bits_q   <= pwdata[gnc_pkg::WordW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gnc_pkg::RegGridWidth:  prdata = 32'(grid_width_q);
      gnc_pkg::RegGridHeight: prdata = 32'(grid_height_q);
      gnc_pkg::RegHexPack:    prdata = 32'(hex_pack_q);
      default:                prdata = 32'(live_bits_q);
    endcase
  end

  assign eff_w = (grid_width_q  > gnc_pkg::MaxColsDim) ? gnc_pkg::MaxColsDim : grid_width_q;
  assign eff_h = (grid_height_q > gnc_pkg::MaxRowsDim) ? gnc_pkg::MaxRowsDim : grid_height_q;

  // item registers
  logic                      cmd_q;
  logic [gnc_pkg::RowW-1:0]  row_q;
  logic [gnc_pkg::ColW-1:0]  col_q;
  logic [gnc_pkg::WordW-1:0] word_q;
  logic                      pos_valid_q;
  logic                      in_accept, pos_valid_in;

  gnc_pkg::ctrl_t      ctrl;
  gnc_pkg::seq_status_t status;
  logic                busy, emit_go, do_emit;

  assign in_stall_o   = busy;
  assign in_accept    = in_valid_i && !busy;
  assign pos_valid_in = ({1'b0, row_index_i} < eff_h) && ({1'b0, col_index_i} < eff_w);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q       <= cmd_i;
      row_q       <= row_index_i;
      col_q       <= col_index_i;
      word_q      <= flag_word_i;
      pos_valid_q <= pos_valid_in;
    end
  end

  assign status.pos_valid = pos_valid_q;
  assign status.is_write  = (gnc_pkg::cmd_e'(cmd_q) == gnc_pkg::CmdWrite);
  assign status.hex       = hex_pack_q;

  assign emit_go = !out_valid_o || !out_stall_i;
  assign do_emit = busy && (ctrl.op == gnc_pkg::OpEmit) && emit_go;

  gnc_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .status_i  (status),
    .emit_go_i (emit_go),
    .busy_o    (busy),
    .ctrl_o    (ctrl)
  );

  // neighbor address and bounds
  logic [2:0]               dc_eff;
  logic signed [SW-1:0]     nbr_r, nbr_c;
  logic                     nbr_inside;
  logic [gnc_pkg::AddrW-1:0] nbr_addr, mem_addr;

  always_comb begin
    dc_eff = {ctrl.dc[1], ctrl.dc};
    if (ctrl.hex_adj && !row_q[0]) begin
      dc_eff = dc_eff - 3'd1;
    end
  end

  assign nbr_r = $signed({2'b00, row_q}) + $signed({{(SW-2){ctrl.dr[1]}}, ctrl.dr});
  assign nbr_c = $signed({2'b00, col_q}) + $signed({{(SW-3){dc_eff[2]}}, dc_eff});
  assign nbr_inside = !nbr_r[SW-1] && !nbr_c[SW-1]
                      && (nbr_r[gnc_pkg::DimW-1:0] < eff_h)
                      && (nbr_c[gnc_pkg::DimW-1:0] < eff_w);
  assign nbr_addr = {nbr_r[gnc_pkg::RowW-1:0], nbr_c[gnc_pkg::ColW-1:0]};
  assign mem_addr = (ctrl.op == gnc_pkg::OpNbr) ? nbr_addr : {row_q, col_q};

  // flag memory: one port, registered read
  logic [gnc_pkg::WordW-1:0] mem_q [gnc_pkg::MaxRows*gnc_pkg::MaxCols];
  logic [gnc_pkg::WordW-1:0] rdata_q;
  logic                      mem_we;

  assign mem_we = busy && (ctrl.op == gnc_pkg::OpWr);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= word_q;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // count and centre word
  logic                      nbr_pend_q, ctr_pend_q;
  logic [gnc_pkg::CntW-1:0]  count_q, count_d;
  logic [gnc_pkg::WordW-1:0] stored_q, stored_d;
  logic                      hit;

  assign hit     = nbr_pend_q && (|(rdata_q & live_bits_q));
  assign count_d = in_accept ? '0 : count_q + gnc_pkg::CntW'(hit);

  always_comb begin
    stored_d = stored_q;
    if (in_accept) begin
      stored_d = '0;
    end else if (mem_we) begin
      stored_d = word_q;
    end else if (ctr_pend_q) begin
      stored_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_pend_q <= 1'b0;
      ctr_pend_q <= 1'b0;
    end else begin
      nbr_pend_q <= busy && (ctrl.op == gnc_pkg::OpNbr) && nbr_inside;
      ctr_pend_q <= busy && (ctrl.op == gnc_pkg::OpCtr) && pos_valid_q && !status.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    stored_q <= stored_d;
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      live_count_o     <= count_q + gnc_pkg::CntW'(hit);
      stored_word_o    <= stored_q;
      position_valid_o <= pos_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/gnc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  live_count_o,
  input logic [15:0] stored_word_o,
  input logic        position_valid_o
);

  `GNC_ASSERT(a_count_max, out_valid_o |-> live_count_o <= 4'd8, "live count above eight")

  `GNC_ASSERT(a_invalid_zero, out_valid_o && !position_valid_o |-> live_count_o == 4'd0 && stored_word_o == 16'd0, "invalid position with nonzero result")

  `GNC_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input taken while an item is in flight")

  `GNC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(stored_word_o) && $stable(live_count_o), "stalled result beat changed")

endmodule

bind grid_live_neighbor_count_core gnc_checker u_gnc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .live_count_o     (live_count_o),
  .stored_word_o    (stored_word_o),
  .position_valid_o (position_valid_o)
);
